@@ rtl/qdec_pkg.sv @@
// ----------------------------------------------------------------------------
// qdec_pkg
// Shared types and fixed widths for the quadrature decoder with speed output.
// ----------------------------------------------------------------------------
package qdec_pkg;

	localparam int POS_W     = 12;  // wrapped position
	localparam int CPT_W     = 13;  // counts per turn register
	localparam int DELTA_W   = 13;  // signed position change
	localparam int VEL_W     = 32;  // signed fixed-point velocity
	localparam int FLAGS_W   = 4;
	localparam int TS_W      = 16;  // timestamp field
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 64;

	localparam logic [CPT_W-1:0] CPT_MIN = 13'd4;
	localparam logic [CPT_W-1:0] CPT_MAX = 13'd4096;
	localparam logic [CPT_W-1:0] CPT_RST = 13'd3600;

	// edge flag bit positions, applied in this order
	localparam int FLAG_B_FALL = 0;
	localparam int FLAG_A_FALL = 1;
	localparam int FLAG_B_RISE = 2;
	localparam int FLAG_A_RISE = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_EDGE,
		ST_CALC,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

endpackage

@@ rtl/qdec_div.sv @@
// ----------------------------------------------------------------------------
// qdec_div
// Radix-2 restoring divider, one quotient bit per step. Used both for the
// position modulo and for the velocity quotient.
// ----------------------------------------------------------------------------
module qdec_div #(
	parameter int DW = 28,
	parameter int RW = 16
) (
	input  logic              clk,
	input  qdec_pkg::div_ctrl_t ctrl,
	input  logic [DW-1:0]     dividend,
	input  logic [RW-1:0]     divisor,
	output logic [DW-1:0]     quotient,
	output logic [RW-1:0]     remainder
);
	import qdec_pkg::*;

	logic [DW-1:0] quot_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] div_q;
	logic [RW:0]   partial;
	logic [RW+1:0] trial;
	logic          borrow;

	// partial < 2 * divisor, so one extra bit holds the borrow
	assign partial = {rem_q, quot_q[DW-1]};
	assign trial   = {1'b0, partial} - {2'b00, div_q};
	assign borrow  = trial[RW+1];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (ctrl.step) begin
			quot_q <= {quot_q[DW-2:0], ~borrow};
			rem_q  <= borrow ? partial[RW-1:0] : trial[RW-1:0];
		end
	end

	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule

@@ rtl/quadrature_decoder_with_speed.sv @@
// ----------------------------------------------------------------------------
// quadrature_decoder_with_speed
// x4 quadrature decoder: position modulo counts per turn, delta since the
// previous event and a signed fixed-point velocity delta / time difference.
//
//  channel | dir | payload
//  --------+-----+----------------------------------------------------------
//  s_*     | in  | tdata: edge_flags, level_a, level_b, timestamp
//  m_*     | out | tdata: position, delta, velocity; tuser: time_zero
//  cfg_*   | in  | counts_per_turn write
//
// One item passes ST_MOD, ST_EDGE, ST_CALC, ST_DIV and ST_FIN before the next
// accept; ST_DIV is skipped when the time difference is zero. The shared
// restoring divider first reduces the position modulo the register, then forms
// the velocity quotient with FRAC_BITS fraction bits. arst_n clears position,
// history and the register (to 3600). A stalled output holds the finished item;
// the next one is accepted meanwhile and waits in ST_FIN for the slot to free.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_speed #(
	parameter int FRAC_BITS = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [qdec_pkg::CPT_W-1:0]        cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// edge_flags[3:0], level_a[4], level_b[5], timestamp[21:6], zero pad
	input  logic [qdec_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// position[11:0], delta[24:12], velocity[56:25], zero pad
	output logic [qdec_pkg::OUT_DATA_W-1:0]   m_tdata,
	// time_zero[0]
	output logic [0:0]                        m_tuser
);
	import qdec_pkg::*;

	localparam int TW = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;
	localparam int DW = POS_W + FRAC_BITS;
	localparam int RW = (TW > CPT_W) ? TW : CPT_W;
	localparam int CW = $clog2(DW + 1);
	localparam int QX = (DW >= 33) ? DW : 33;
	localparam logic [QX-1:0] Q_LIM = QX'(64'h8000_0000);

	function automatic logic [POS_W-1:0] step_cnt(
		input logic [POS_W-1:0] c,
		input logic             up,
		input logic [CPT_W-1:0] n
	);
		logic [CPT_W-1:0] inc;
		logic [CPT_W-1:0] top;
		inc = {1'b0, c} + CPT_W'(1);
		top = n - CPT_W'(1);
		if (up)
			return (inc >= n) ? '0 : inc[POS_W-1:0];
		return (c == '0) ? top[POS_W-1:0] : c - POS_W'(1);
	endfunction

	state_t state_q, state_nx;
	logic [CW-1:0]      step_q;
	logic [CPT_W-1:0]   cfg_q;
	logic [CPT_W-1:0]   turn;
	logic [POS_W-1:0]   count_q, last_pos_q;
	logic [TW-1:0]      last_time_q, ts_q;
	logic [FLAGS_W-1:0] flags_q;
	logic               a_q, b_q;
	logic               neg_q, tz_q;
	logic [DELTA_W-1:0] delta_q;

	logic               m_valid_q;
	logic [POS_W-1:0]   pos_out_q;
	logic [DELTA_W-1:0] delta_out_q;
	logic [VEL_W-1:0]   vel_out_q;
	logic               tz_out_q;

	div_ctrl_t          div_ctrl;
	logic [DW-1:0]      div_dividend, div_quot;
	logic [RW-1:0]      div_divisor, div_rem;
	logic               accept, fin_write, out_free;
	logic               step_last;

	logic [POS_W-1:0]   c0, c1, c2, c3, c4;
	logic [DELTA_W-1:0] delta_c;
	logic [POS_W-1:0]   delta_mag;
	logic [TW:0]        dt_c;
	logic [TW-1:0]      dt_mag;
	logic [QX-1:0]      qx;
	logic [VEL_W-1:0]   vel_c;

	assign turn = (cfg_q < CPT_MIN) ? CPT_MIN : ((cfg_q > CPT_MAX) ? CPT_MAX : cfg_q);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// edge application on the reduced count
	assign c0 = div_rem[POS_W-1:0];
	assign c1 = flags_q[FLAG_B_FALL] ? step_cnt(c0, !a_q, turn) : c0;
	assign c2 = flags_q[FLAG_A_FALL] ? step_cnt(c1, b_q, turn) : c1;
	assign c3 = flags_q[FLAG_B_RISE] ? step_cnt(c2, a_q, turn) : c2;
	assign c4 = flags_q[FLAG_A_RISE] ? step_cnt(c3, !b_q, turn) : c3;

	assign delta_c   = {1'b0, count_q} - {1'b0, last_pos_q};
	assign delta_mag = delta_c[DELTA_W-1] ? POS_W'(-delta_c) : delta_c[POS_W-1:0];
	assign dt_c      = {1'b0, ts_q} - {1'b0, last_time_q};
	assign dt_mag    = dt_c[TW] ? TW'(-dt_c) : dt_c[TW-1:0];

	// sign fix and saturation of the quotient magnitude
	assign qx = QX'(div_quot);
	always_comb begin
		if (tz_q)
			vel_c = '0;
		else if (neg_q)
			vel_c = (qx > Q_LIM) ? 32'h8000_0000 : VEL_W'(-qx);
		else
			vel_c = (qx >= Q_LIM) ? 32'h7FFF_FFFF : qx[VEL_W-1:0];
	end

	assign step_last = (state_q == ST_MOD) ? (step_q == CW'(POS_W - 1))
	                                       : (step_q == CW'(DW - 1));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_nx = ST_MOD;
			ST_MOD:  if (step_last) state_nx = ST_EDGE;
			ST_EDGE: state_nx = ST_CALC;
			ST_CALC: state_nx = (dt_c == '0) ? ST_FIN : ST_DIV;
			ST_DIV:  if (step_last) state_nx = ST_FIN;
			ST_FIN:  if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		div_ctrl      = '0;
		fin_write     = 1'b0;
		div_dividend  = DW'(count_q) << FRAC_BITS;
		div_divisor   = RW'(turn);
		unique case (state_q)
			ST_IDLE: begin
				s_tready      = 1'b1;
				div_ctrl.load = s_tvalid;
			end
			ST_MOD, ST_DIV: div_ctrl.step = 1'b1;
			ST_CALC: begin
				div_ctrl.load = 1'b1;
				div_dividend  = DW'(delta_mag) << FRAC_BITS;
				div_divisor   = RW'(dt_mag);
			end
			ST_FIN:  fin_write = out_free;
			default: ;
		endcase
	end

	qdec_div #(
		.DW(DW),
		.RW(RW)
	) u_div (
		.clk       (clk),
		.ctrl      (div_ctrl),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			cfg_q       <= CPT_RST;
			count_q     <= '0;
			last_pos_q  <= '0;
			last_time_q <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we)
				cfg_q <= cfg_wdata;
			if (div_ctrl.load)
				step_q <= '0;
			else if (div_ctrl.step)
				step_q <= step_q + CW'(1);
			if (state_q == ST_EDGE)
				count_q <= c4;
			if (state_q == ST_CALC) begin
				last_pos_q  <= count_q;
				last_time_q <= ts_q;
			end
			if (fin_write)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_q <= s_tdata[FLAGS_W-1:0];
			a_q     <= s_tdata[FLAGS_W];
			b_q     <= s_tdata[FLAGS_W+1];
			ts_q    <= s_tdata[FLAGS_W+2 +: TW];
		end
		if (state_q == ST_CALC) begin
			delta_q <= delta_c;
			neg_q   <= delta_c[DELTA_W-1] ^ dt_c[TW];
			tz_q    <= (dt_c == '0);
		end
		if (fin_write) begin
			pos_out_q   <= count_q;
			delta_out_q <= delta_q;
			vel_out_q   <= vel_c;
			tz_out_q    <= tz_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_W'({vel_out_q, delta_out_q, pos_out_q});
	assign m_tuser  = tz_out_q;

endmodule
